// ----- rtl/ocm_pkg.sv -----
// Shared types, constants and codes for the counting occupancy cell map.
`timescale 1ns / 1ps

package ocm_pkg;

    // Table geometry and count width
    localparam int unsigned CELLS      = 65536;
    localparam int unsigned COUNT_BITS = 16;
    localparam int unsigned ADDR_BITS  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int unsigned WORD_BITS  = 2 * COUNT_BITS;

    // Ratio threshold in 1/256 units
    localparam int unsigned THR_BITS   = 9;
    localparam int unsigned THR_RESET  = 64;
    localparam int unsigned FRAC_BITS  = 8;
    localparam int unsigned PROD_BITS  = THR_BITS + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Operation codes
    localparam logic [1:0] FUNC_FREE  = 2'd0;
    localparam logic [1:0] FUNC_OCC   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_QUERY = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic        changed;
        logic        is_free;
        logic        is_occupied;
        logic        is_unknown;
        logic [15:0] hit_count;
        logic [15:0] visit_count;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic rd_en;
        logic calc_en;
        logic eval_wr;
        logic clr_wr;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
    } t_dp_sts;

endpackage

// ----- rtl/ocm_datapath.sv -----
// Datapath: cell count memory, update arithmetic, ratio compare and result register.
`timescale 1ns / 1ps

module ocm_datapath
    import ocm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THR_BITS-1:0] i_cfg_data,
    input  t_in_item            i_item,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output t_out_item           o_result
);

    logic [WORD_BITS-1:0]  mem [CELLS];
    logic [WORD_BITS-1:0]  r_rd_data;

    logic [THR_BITS-1:0]   r_thr;
    logic [ADDR_BITS-1:0]  r_clr_addr;

    t_in_item              r_item;
    logic                  r_in_range;
    logic [COUNT_BITS-1:0] r_old_h, r_old_v, r_new_h, r_new_v;
    logic [PROD_BITS-1:0]  r_prod_old, r_prod_new;
    t_out_item             r_out;

    logic [ADDR_BITS-1:0]  addr;
    logic                  in_range;
    logic [COUNT_BITS-1:0] old_h, old_v, n_new_h, n_new_v;
    logic [PROD_BITS-1:0]  n_prod_old, n_prod_new;
    logic [PROD_BITS-1:0]  scaled_old, scaled_new;
    logic                  free_old, occ_old, free_new, occ_new, chg;
    t_out_item             n_out;

    assign addr     = ADDR_BITS'(r_item.cell_index);
    assign in_range = 32'(r_item.cell_index) < 32'(CELLS);

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_BITS'(THR_RESET);
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // Clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
        end
    end

    assign o_sts.clr_last = (r_clr_addr == ADDR_BITS'(CELLS - 1));

    // Count memory: one write port shared by the sweep and the update
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.eval_wr && r_in_range) begin
            mem[addr] <= {r_new_h, r_new_v};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[addr];
        end
    end

    // Update the counts; an index beyond the table reads as an empty cell
    always_comb begin
        old_h   = in_range ? r_rd_data[WORD_BITS-1:COUNT_BITS] : '0;
        old_v   = in_range ? r_rd_data[COUNT_BITS-1:0] : '0;
        n_new_h = old_h;
        n_new_v = old_v;
        case (r_item.func)
            FUNC_FREE: begin
                if (old_v != COUNT_MAX) n_new_v = old_v + COUNT_BITS'(1);
            end
            FUNC_OCC: begin
                if (old_v != COUNT_MAX) begin
                    n_new_v = old_v + COUNT_BITS'(1);
                    if (old_h != COUNT_MAX) n_new_h = old_h + COUNT_BITS'(1);
                end
            end
            FUNC_CLEAR: begin
                n_new_h = '0;
                n_new_v = '0;
            end
            default: begin
            end
        endcase
        n_prod_old = PROD_BITS'(r_thr) * PROD_BITS'(old_v);
        n_prod_new = PROD_BITS'(r_thr) * PROD_BITS'(n_new_v);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.calc_en) begin
            r_in_range <= in_range;
            r_old_h    <= old_h;
            r_old_v    <= old_v;
            r_new_h    <= n_new_h;
            r_new_v    <= n_new_v;
            r_prod_old <= n_prod_old;
            r_prod_new <= n_prod_new;
        end
    end

    // Compare hits*256 against threshold*visits before and after
    always_comb begin
        scaled_old = PROD_BITS'({r_old_h, FRAC_BITS'(0)});
        scaled_new = PROD_BITS'({r_new_h, FRAC_BITS'(0)});
        free_old   = (r_old_v != '0) && (scaled_old < r_prod_old);
        occ_old    = (r_old_v != '0) && (scaled_old > r_prod_old);
        free_new   = (r_new_v != '0) && (scaled_new < r_prod_new);
        occ_new    = (r_new_v != '0) && (scaled_new > r_prod_new);
        case (r_item.func)
            FUNC_FREE:  chg = !free_old && free_new;
            FUNC_OCC:   chg = !occ_old && occ_new;
            FUNC_CLEAR: chg = (r_old_v != '0);
            default:    chg = 1'b0;
        endcase
        n_out.changed     = chg;
        n_out.is_free     = free_new;
        n_out.is_occupied = occ_new;
        n_out.is_unknown  = (r_new_v == '0);
        n_out.hit_count   = 16'(r_new_h);
        n_out.visit_count = 16'(r_new_v);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_wr) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

// ----- rtl/ocm_ctrl.sv -----
// Controller: clearing sweep, per-item sequencing and output valid.
`timescale 1ns / 1ps

module ocm_ctrl
    import ocm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       can_load;

    // The result register is free when empty or being taken this cycle
    assign can_load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc_en = 1'b1;
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                // Hold until the result register can take the item
                if (can_load) begin
                    o_cmd.eval_wr = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/counting_occupancy_cell_map.sv -----
// Top level of the counting occupancy cell map.
// After reset the block sweeps its cell memory to zero, one cell per cycle, over all 65536 cells,
// with input stall held high; threshold writes are taken during the sweep. Each item then holds
// the block through accept, memory read, count update and multiply, and compare and write back,
// so a new item is accepted only once the previous one is written back. The result is loaded in
// the compare and write back step, which waits while a previous result still sits in a stalled
// output register. Items pass through the read-modify-write sequence on the cell memory one at a
// time. A finished result waits in the output register while the next item is accepted. Results
// show the cell's counts and flags after the item.
`timescale 1ns / 1ps

module counting_occupancy_cell_map
    import ocm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THR_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_result
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    ocm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ocm_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (o_result)
    );

endmodule

// ----- rtl/ocm_checker.sv -----
// Port-level checker for the counting occupancy cell map, bound to the top level.
`timescale 1ns / 1ps

module ocm_checker
    import ocm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_result
);

    // The clearing sweep must block input right after reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // One item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted on consecutive cycles");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result)))
        else $error("stalled result changed");

    a_flags_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!(o_result.is_free && o_result.is_occupied)
                         && (o_result.is_unknown == (o_result.visit_count == 16'd0))
                         && !(o_result.is_unknown && (o_result.is_free || o_result.is_occupied))))
        else $error("inconsistent cell flags");

endmodule

bind counting_occupancy_cell_map ocm_checker u_ocm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_result    (o_result)
);

// ----- tb/counting_occupancy_cell_map_tb.sv -----
// Self-checking testbench for the counting occupancy cell map.
`timescale 1ns / 1ps

module counting_occupancy_cell_map_tb;
    import ocm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned PHASE_ITEMS = 170;
    localparam int unsigned POOL_CELLS  = 12;
    localparam int unsigned BURST_CYCLES = 400;
    localparam int unsigned MAX_REPORTS = 40;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_cfg_we   = 1'b0;
    logic [THR_BITS-1:0] i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_item            i_item     = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b1;
    t_out_item           o_result;

    counting_occupancy_cell_map DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_item      (i_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result)
    );

    // Shadow copy of the cell table and threshold
    bit [COUNT_BITS-1:0] cell_hits   [CELLS];
    bit [COUNT_BITS-1:0] cell_visits [CELLS];
    logic [THR_BITS-1:0] thr_shadow = THR_BITS'(THR_RESET);

    t_in_item  pending_items[$];
    t_out_item expected_cells[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          send_hold     = 1'b0;
    bit          burst_req     = 1'b0;
    int unsigned burst_left    = 0;

    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned changed_seen  = 0;
    int unsigned peak_visits   = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit ratio_free(logic [COUNT_BITS-1:0] hits, logic [COUNT_BITS-1:0] visits);
        if (visits == '0) return 1'b0;
        return (64'(hits) << FRAC_BITS) < 64'(thr_shadow) * 64'(visits);
    endfunction

    function automatic bit ratio_occupied(logic [COUNT_BITS-1:0] hits,
                                          logic [COUNT_BITS-1:0] visits);
        if (visits == '0) return 1'b0;
        return (64'(hits) << FRAC_BITS) > 64'(thr_shadow) * 64'(visits);
    endfunction

    // Apply one item to the shadow table and return the cell's state after it
    function automatic t_out_item update_cell(t_in_item it);
        t_out_item             res;
        logic [COUNT_BITS-1:0] hits;
        logic [COUNT_BITS-1:0] visits;
        bit                    was_set;
        res    = '0;
        hits   = cell_hits[it.cell_index];
        visits = cell_visits[it.cell_index];
        case (it.func)
            FUNC_FREE: begin
                was_set = ratio_free(hits, visits);
                if (visits != COUNT_MAX) visits++;
                res.changed = !was_set && ratio_free(hits, visits);
            end
            FUNC_OCC: begin
                was_set = ratio_occupied(hits, visits);
                if (visits != COUNT_MAX) begin
                    visits++;
                    if (hits != COUNT_MAX) hits++;
                end
                res.changed = !was_set && ratio_occupied(hits, visits);
            end
            FUNC_CLEAR: begin
                res.changed = (visits != '0);
                hits   = '0;
                visits = '0;
            end
            default: ;
        endcase
        cell_hits[it.cell_index]   = hits;
        cell_visits[it.cell_index] = visits;
        res.is_free     = ratio_free(hits, visits);
        res.is_occupied = ratio_occupied(hits, visits);
        res.is_unknown  = (visits == '0);
        res.hit_count   = hits;
        res.visit_count = visits;
        return res;
    endfunction

    // Sender: hold the payload while stalled, otherwise offer the next item or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_cells.push_back(update_cell(i_item));
                items_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() > 0 && !send_hold &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    i_item     <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (burst_req) begin
            burst_left = BURST_CYCLES;
            burst_req  = 1'b0;
        end
        if (burst_left > 0) begin
            burst_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_cells.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: expected none, got %h", $time, o_result);
            end else begin
                want = expected_cells.pop_front();
                check_field("changed", 16'(want.changed), 16'(o_result.changed));
                check_field("is_free", 16'(want.is_free), 16'(o_result.is_free));
                check_field("is_occupied", 16'(want.is_occupied), 16'(o_result.is_occupied));
                check_field("is_unknown", 16'(want.is_unknown), 16'(o_result.is_unknown));
                check_field("hit_count", want.hit_count, o_result.hit_count);
                check_field("visit_count", want.visit_count, o_result.visit_count);
                if (want.changed) changed_seen++;
                if (32'(want.visit_count) > peak_visits) peak_visits = 32'(want.visit_count);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_cells.size());
            $display("FAIL counting_occupancy_cell_map");
            $finish;
        end
    end

    task automatic push_item(logic [1:0] func, logic [15:0] cell_idx);
        t_in_item it;
        it.func       = func;
        it.cell_index = cell_idx;
        pending_items.push_back(it);
    endtask

    // Mostly marks on a small pool of cells so counts build up; a few scattered cells
    task automatic push_random_items(int unsigned count);
        logic [15:0] pool [POOL_CELLS];
        logic [15:0] cell_idx;
        logic [1:0]  func;
        int unsigned pick;
        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
        for (int k = 2; k < POOL_CELLS; k++) pool[k] = 16'($urandom_range(0, 65535));
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 8) cell_idx = 16'($urandom_range(0, 65535));
            else cell_idx = pool[$urandom_range(0, POOL_CELLS - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 40)      func = FUNC_FREE;
            else if (pick < 75) func = FUNC_OCC;
            else if (pick < 82) func = FUNC_CLEAR;
            else                func = FUNC_QUERY;
            push_item(func, cell_idx);
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_in_valid || expected_cells.size() > 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        thr_shadow = value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial begin
        logic [THR_BITS-1:0] thr_plan [6];
        thr_plan = '{9'd0, 9'd511, 9'd256, 9'd257, 9'd128, 9'($urandom_range(1, 255))};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_idling(35, 72);

        // Directed: transitions, repeats, clears, boundary ratio, extreme cells
        push_item(FUNC_QUERY, 16'h0000);
        push_item(FUNC_FREE,  16'h0000);
        push_item(FUNC_FREE,  16'h0000);
        push_item(FUNC_OCC,   16'h0000);
        push_item(FUNC_OCC,   16'h0000);
        push_item(FUNC_CLEAR, 16'h0000);
        push_item(FUNC_CLEAR, 16'h0000);
        push_item(FUNC_QUERY, 16'h0000);
        push_item(FUNC_OCC,   16'hFFFF);
        push_item(FUNC_QUERY, 16'hFFFF);
        push_item(FUNC_FREE,  16'hFFFF);
        // one hit in four visits sits exactly on the reset threshold
        push_item(FUNC_OCC,   16'h5555);
        push_item(FUNC_FREE,  16'h5555);
        push_item(FUNC_FREE,  16'h5555);
        push_item(FUNC_FREE,  16'h5555);
        push_item(FUNC_QUERY, 16'h5555);
        push_item(FUNC_FREE,  16'h5555);
        push_item(FUNC_OCC,   16'hAAAA);
        push_item(FUNC_CLEAR, 16'hAAAA);
        push_item(FUNC_QUERY, 16'h8001);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            write_threshold(thr_plan[p]);
            if (p < 2)      set_idling(35, 72);
            else if (p < 4) set_idling(72, 35);
            else            set_idling(0, 0);
            if (p == 1) begin
                push_random_items(PHASE_ITEMS / 2);
                while (pending_items.size() > 0) @(negedge i_clk);
                // pause the sender until the block has emptied
                send_hold = 1'b1;
                wait_drained();
                send_hold = 1'b0;
                push_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                push_random_items(PHASE_ITEMS);
                if (p == 4) burst_req = 1'b1;
            end
            wait_drained();
        end
        repeat (20) @(negedge i_clk);

        if (expected_cells.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, expected_cells.size());
        end
        $display("Covered %0d items and %0d results across thresholds 0 to 511, %0d changes.",
                 items_sent, results_seen, changed_seen);
        $display("Peak visit count %0d; stall bursts and sender pauses exercised.",
                 peak_visits);
        if (error_count == 0) begin
            $display("PASS counting_occupancy_cell_map");
        end else begin
            $display("FAIL counting_occupancy_cell_map");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ocm_pkg.sv
rtl/ocm_datapath.sv
rtl/ocm_ctrl.sv
rtl/counting_occupancy_cell_map.sv
rtl/ocm_checker.sv
tb/counting_occupancy_cell_map_tb.sv
